>>> src/tei_pkg.sv
// Shared types, constants and codes for the tree ensemble inference unit.
package tei_pkg;

  // Default sizing
  localparam int unsigned NUM_TREES_DEF      = 8;
  localparam int unsigned NODES_PER_TREE_DEF = 256;
  localparam int unsigned WALK_DEPTH_DEF     = 16;

  // Number of feature inputs that carry real values
  localparam int unsigned NUM_FEATURES  = 8;
  localparam int unsigned FEAT_W        = 32;
  localparam int unsigned ADDR_W        = 11;
  localparam int unsigned WORD_W        = 64;
  localparam int unsigned SPLIT_W       = 37;
  localparam int unsigned LINK_W        = 50;
  localparam int unsigned CONF_W        = 17;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_TREES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT  = 2'd1;
  localparam logic [3:0] TREES_RESET = 4'd0;
  localparam logic [4:0] DEPTH_RESET = 5'd16;

  // Request field codes
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_PREDICT = 1'b1;
  localparam logic WSEL_SPLIT  = 1'b0;
  localparam logic WSEL_LINK   = 1'b1;

  // Fixed-point constant one in Q1.16
  localparam logic [CONF_W-1:0] Q_ONE = 17'h10000;

  typedef enum logic [1:0] {
    ITEM_WR_SPLIT,
    ITEM_WR_LINK,
    ITEM_PREDICT,
    ITEM_DROP
  } item_kind_e;

  typedef struct packed {
    item_kind_e                          kind;
    logic [ADDR_W-1:0]                   addr;
    logic [WORD_W-1:0]                   word;
    logic [NUM_FEATURES-1:0][FEAT_W-1:0] feat;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_DIV_MEAN,
    ST_VAR_RD,
    ST_VAR_AB,
    ST_VAR_M0,
    ST_VAR_M1,
    ST_VAR_M2,
    ST_VAR_M3,
    ST_DIV_VAR,
    ST_SQRT,
    ST_OUT
  } back_state_e;

endpackage

>>> src/tei_chan_if.sv
// Request and response channel interfaces of the tree ensemble inference unit.
interface tei_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [10:0]        node_address;
  logic               word_select;
  logic [63:0]        node_word;
  logic signed [31:0] sma_short_ratio;
  logic signed [31:0] sma_long_ratio;
  logic signed [31:0] rsi_value;
  logic signed [31:0] volatility_value;
  logic signed [31:0] volume_ratio_value;
  logic signed [31:0] momentum_short;
  logic signed [31:0] momentum_long;
  logic signed [31:0] sentiment_value;

  modport source (
    output valid, cmd, node_address, word_select, node_word,
           sma_short_ratio, sma_long_ratio, rsi_value, volatility_value,
           volume_ratio_value, momentum_short, momentum_long, sentiment_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, node_address, word_select, node_word,
           sma_short_ratio, sma_long_ratio, rsi_value, volatility_value,
           volume_ratio_value, momentum_short, momentum_long, sentiment_value,
    output ready
  );
endinterface

interface tei_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] predicted_mean;
  logic [31:0]        spread_variance;
  logic [16:0]        confidence;
  logic               untrained;
  logic               depth_exceeded;

  modport source (
    output valid, predicted_mean, spread_variance, confidence, untrained,
           depth_exceeded,
    input  ready
  );
  modport sink (
    input  valid, predicted_mean, spread_variance, confidence, untrained,
           depth_exceeded,
    output ready
  );
endinterface

>>> src/tei_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module tei_front #(
  parameter int unsigned NUM_TREES      = tei_pkg::NUM_TREES_DEF,
  parameter int unsigned NODES_PER_TREE = tei_pkg::NODES_PER_TREE_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tei_in_if.sink         req,
  output tei_pkg::item_t q_item_o,
  output logic           q_valid_o,
  input  logic           q_pop_i
);

  localparam int unsigned TABLE_DEPTH = NUM_TREES * NODES_PER_TREE;

  tei_pkg::item_t fifo_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  tei_pkg::item_t item_in;
  logic           push;

  // Classify the incoming request
  always_comb begin
    item_in.addr = req.node_address;
    item_in.word = req.node_word;
    item_in.feat = {req.sentiment_value, req.momentum_long, req.momentum_short,
                    req.volume_ratio_value, req.volatility_value, req.rsi_value,
                    req.sma_long_ratio, req.sma_short_ratio};
    if (req.cmd == tei_pkg::CMD_PREDICT) begin
      item_in.kind = tei_pkg::ITEM_PREDICT;
    end else if (32'(req.node_address) >= 32'(TABLE_DEPTH)) begin
      item_in.kind = tei_pkg::ITEM_DROP;
    end else if (req.word_select == tei_pkg::WSEL_LINK) begin
      item_in.kind = tei_pkg::ITEM_WR_LINK;
    end else begin
      item_in.kind = tei_pkg::ITEM_WR_SPLIT;
    end
  end

  assign req.ready = (cnt_q != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = fifo_q[rd_ptr_q];

  // Two-entry queue pointers
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (q_pop_i && q_valid_o) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    unique case ({push, q_pop_i && q_valid_o})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

>>> src/tei_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module tei_div #(
  parameter int unsigned DVW = 52,
  parameter int unsigned DSW = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [DSW-1:0] divisor_i,
  output logic           done_o,
  output logic [DVW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DVW + 1);

  logic           busy_q;
  logic           done_q;
  logic [CW-1:0]  cnt_q;
  logic [DVW-1:0] dq_q;
  logic [DSW-1:0] rem_q;
  logic [DSW-1:0] dsr_q;
  logic [DSW:0]   rem_sh;
  logic           ge;
  logic [DSW:0]   rem_sub;

  // One shift-subtract step
  assign rem_sh  = {rem_q, dq_q[DVW-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dq_q   <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        dq_q   <= dividend_i;
        rem_q  <= '0;
        dsr_q  <= divisor_i;
      end else if (busy_q) begin
        dq_q  <= {dq_q[DVW-2:0], ge};
        rem_q <= ge ? rem_sub[DSW-1:0] : rem_sh[DSW-1:0];
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DVW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

>>> src/tei_back.sv
// Back end: node tables, tree walker, mean/variance/confidence sequencer.
module tei_back #(
  parameter int unsigned NUM_TREES      = tei_pkg::NUM_TREES_DEF,
  parameter int unsigned NODES_PER_TREE = tei_pkg::NODES_PER_TREE_DEF,
  parameter int unsigned WALK_DEPTH     = tei_pkg::WALK_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tei_pkg::item_t q_item_i,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  input  logic [3:0]     trees_in_use_i,
  input  logic [4:0]     depth_limit_i,
  tei_out_if.source      rsp
);

  localparam int unsigned TD   = NUM_TREES * NODES_PER_TREE;
  localparam int unsigned AW   = $clog2(TD);
  localparam int unsigned NIW  = $clog2(NODES_PER_TREE);
  localparam int unsigned NW   = $clog2(NUM_TREES + 1);
  localparam int unsigned PW   = (NUM_TREES > 1) ? $clog2(NUM_TREES) : 1;
  localparam int unsigned SW   = $clog2(WALK_DEPTH + 1);
  localparam int unsigned SUMW = 33 + $clog2(NUM_TREES);
  localparam int unsigned SSW  = 65 + $clog2(NUM_TREES);
  localparam int unsigned DVW  = SSW - 16;

  // Node tables and per-tree outputs
  logic [tei_pkg::SPLIT_W-1:0] split_mem [TD];
  logic [tei_pkg::LINK_W-1:0]  link_mem  [TD];
  logic [31:0]                 pred_mem  [NUM_TREES];
  logic [tei_pkg::SPLIT_W-1:0] split_rd_q;
  logic [tei_pkg::LINK_W-1:0]  link_rd_q;
  logic [31:0]                 pred_rd_q;

  // Child index wrap table
  logic [NIW-1:0] wrap_tab [256];
  for (genvar g = 0; g < 256; g++) begin : g_wrap
    assign wrap_tab[g] = NIW'(g % NODES_PER_TREE);
  end

  tei_pkg::back_state_e state_q, state_d;
  logic [tei_pkg::NUM_FEATURES-1:0][31:0] feat_q, feat_d;
  logic [NW-1:0]   n_q, n_d, t_q, t_d;
  logic [AW-1:0]   base_q, base_d;
  logic [NIW-1:0]  node_q, node_d;
  logic [SW-1:0]   steps_q, steps_d, lim_q, lim_d;
  logic [SUMW-1:0] sum_q, sum_d;
  logic            exc_q, exc_d, untr_q, untr_d, neg_q, neg_d;
  logic [31:0]     mean_q, mean_d, var_q, var_d;
  logic [SSW-1:0]  ss_q, ss_d;
  logic [32:0]     a_q, a_d;
  logic [33:0]     prod_q, prod_d;
  logic [47:0]     sv_q, sv_d, sres_q, sres_d, sbit_q, sbit_d;
  logic [4:0]      scnt_q, scnt_d;
  logic            ov_q, ov_d;
  logic [31:0]     o_mean_q, o_mean_d, o_var_q, o_var_d;
  logic [16:0]     o_conf_q, o_conf_d;
  logic            o_untr_q, o_untr_d, o_exc_q, o_exc_d;

  logic            split_we, link_we, pred_we;
  logic [AW-1:0]   wr_idx, rd_idx;
  logic [31:0]     pred_wd;
  logic            div_start, div_done;
  logic [DVW-1:0]  div_dvd, div_quo;
  logic [16:0]     mul_a, mul_b;
  logic [6:0]      lim7;
  logic [7:0]      ntr8;

  // Walk-step decode
  logic [3:0]         code;
  logic signed [31:0] fval, thr, leafval;
  logic               go_l, go_r;
  logic [7:0]         next8;
  logic signed [32:0] dif;
  logic [SUMW-1:0]    sum_abs;
  logic [47:0]        strial;
  logic [23:0]        root;

  assign wr_idx  = AW'(q_item_i.addr);
  assign rd_idx  = base_q + AW'(node_q);
  assign code    = split_rd_q[4:1];
  assign fval    = (32'(code) < 32'(tei_pkg::NUM_FEATURES)) ? feat_q[code[2:0]] : 32'sd0;
  assign thr     = split_rd_q[36:5];
  assign leafval = link_rd_q[49:18];
  assign go_l    = (fval <= thr) && link_rd_q[0];
  assign go_r    = link_rd_q[9];
  assign next8   = go_l ? link_rd_q[8:1] : link_rd_q[17:10];
  assign dif     = {pred_rd_q[31], pred_rd_q} - {mean_q[31], mean_q};
  assign sum_abs = sum_q[SUMW-1] ? (~sum_q + 1'b1) : sum_q;
  assign strial  = sres_q + sbit_q;
  assign root    = sres_q[23:0];
  assign mul_a   = (state_q == tei_pkg::ST_VAR_M2) ? {1'b0, a_q[15:0]} : a_q[32:16];
  assign mul_b   = (state_q == tei_pkg::ST_VAR_M0) ? a_q[32:16] : {1'b0, a_q[15:0]};

  // Effective tree count and depth limit
  always_comb begin
    ntr8 = {4'd0, trees_in_use_i};
    if (ntr8 > 8'(NUM_TREES)) begin
      ntr8 = 8'(NUM_TREES);
    end
    lim7 = {2'd0, depth_limit_i};
    if (lim7 == 7'd0) begin
      lim7 = 7'd1;
    end
    if (lim7 > 7'(WALK_DEPTH)) begin
      lim7 = 7'(WALK_DEPTH);
    end
  end

  tei_div #(.DVW(DVW), .DSW(NW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Sequencer
  always_comb begin
    state_d  = state_q;   feat_d  = feat_q;   n_d    = n_q;     t_d    = t_q;
    base_d   = base_q;    node_d  = node_q;   steps_d = steps_q; lim_d = lim_q;
    sum_d    = sum_q;     exc_d   = exc_q;    untr_d = untr_q;  neg_d  = neg_q;
    mean_d   = mean_q;    var_d   = var_q;    ss_d   = ss_q;    a_d    = a_q;
    prod_d   = prod_q;    sv_d    = sv_q;     sres_d = sres_q;  sbit_d = sbit_q;
    scnt_d   = scnt_q;    ov_d    = ov_q;     o_mean_d = o_mean_q;
    o_var_d  = o_var_q;   o_conf_d = o_conf_q; o_untr_d = o_untr_q; o_exc_d = o_exc_q;
    q_pop_o  = 1'b0;
    split_we = 1'b0;
    link_we  = 1'b0;
    pred_we  = 1'b0;
    pred_wd  = 32'd0;
    div_start = 1'b0;
    div_dvd   = '0;

    if (rsp.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      tei_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (q_item_i.kind)
            tei_pkg::ITEM_WR_SPLIT: split_we = 1'b1;
            tei_pkg::ITEM_WR_LINK:  link_we  = 1'b1;
            tei_pkg::ITEM_PREDICT: begin
              feat_d  = q_item_i.feat;
              n_d     = NW'(ntr8);
              lim_d   = SW'(lim7);
              t_d     = '0;
              base_d  = '0;
              node_d  = '0;
              steps_d = '0;
              sum_d   = '0;
              exc_d   = 1'b0;
              untr_d  = (ntr8 == 8'd0);
              state_d = (ntr8 == 8'd0) ? tei_pkg::ST_OUT : tei_pkg::ST_WALK_RD;
            end
            default: ;
          endcase
        end
      end
      tei_pkg::ST_WALK_RD: state_d = tei_pkg::ST_WALK_EV;
      tei_pkg::ST_WALK_EV: begin
        if (split_rd_q[0] || !(go_l || go_r) || (steps_q >= lim_q)) begin
          // tree finished: leaf, dead end or depth limit
          pred_we = 1'b1;
          pred_wd = split_rd_q[0] ? leafval : 32'd0;
          if (!split_rd_q[0] && (go_l || go_r)) begin
            exc_d = 1'b1;
          end
          sum_d   = sum_q + {{(SUMW-32){pred_wd[31]}}, pred_wd};
          t_d     = t_q + 1'b1;
          base_d  = base_q + AW'(NODES_PER_TREE);
          node_d  = '0;
          steps_d = '0;
          if (NW'(t_q + 1'b1) == n_q) begin
            state_d = tei_pkg::ST_DIV_MEAN;
          end else begin
            state_d = tei_pkg::ST_WALK_RD;
          end
        end else begin
          steps_d = steps_q + 1'b1;
          node_d  = wrap_tab[next8];
          state_d = tei_pkg::ST_WALK_RD;
        end
      end
      tei_pkg::ST_DIV_MEAN: begin
        if (t_q != '0) begin
          // kick off the divide once, marked by clearing t
          div_start = 1'b1;
          div_dvd   = {{(DVW-SUMW){1'b0}}, sum_abs};
          neg_d     = sum_q[SUMW-1];
          t_d       = '0;
        end else if (div_done) begin
          mean_d  = neg_q ? (~div_quo[31:0] + 32'd1) : div_quo[31:0];
          ss_d    = '0;
          state_d = tei_pkg::ST_VAR_RD;
        end
      end
      tei_pkg::ST_VAR_RD: state_d = tei_pkg::ST_VAR_AB;
      tei_pkg::ST_VAR_AB: begin
        a_d     = dif[32] ? 33'(-dif) : 33'(dif);
        state_d = tei_pkg::ST_VAR_M0;
      end
      tei_pkg::ST_VAR_M0: begin
        prod_d  = mul_a * mul_b;
        state_d = tei_pkg::ST_VAR_M1;
      end
      tei_pkg::ST_VAR_M1: begin
        ss_d    = ss_q + (SSW'(prod_q) << 32);
        prod_d  = mul_a * mul_b;
        state_d = tei_pkg::ST_VAR_M2;
      end
      tei_pkg::ST_VAR_M2: begin
        ss_d    = ss_q + (SSW'(prod_q) << 17);
        prod_d  = mul_a * mul_b;
        state_d = tei_pkg::ST_VAR_M3;
      end
      tei_pkg::ST_VAR_M3: begin
        ss_d = ss_q + SSW'(prod_q);
        t_d  = t_q + 1'b1;
        if (NW'(t_q + 1'b1) == n_q) begin
          state_d = tei_pkg::ST_DIV_VAR;
        end else begin
          state_d = tei_pkg::ST_VAR_RD;
        end
      end
      tei_pkg::ST_DIV_VAR: begin
        if (t_q != '0) begin
          div_start = 1'b1;
          div_dvd   = ss_q[SSW-1:16];
          t_d       = '0;
        end else if (div_done) begin
          var_d   = (|div_quo[DVW-1:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
          sv_d    = {div_quo[31:0], 16'h0000};
          if (|div_quo[DVW-1:32]) begin
            sv_d = {32'hFFFF_FFFF, 16'h0000};
          end
          sres_d  = '0;
          sbit_d  = 48'h4000_0000_0000;
          scnt_d  = '0;
          state_d = tei_pkg::ST_SQRT;
        end
      end
      tei_pkg::ST_SQRT: begin
        // one result bit per cycle
        if (sv_q >= strial) begin
          sv_d   = sv_q - strial;
          sres_d = (sres_q >> 1) + sbit_q;
        end else begin
          sres_d = sres_q >> 1;
        end
        sbit_d = sbit_q >> 2;
        scnt_d = scnt_q + 5'd1;
        if (scnt_q == 5'd23) begin
          state_d = tei_pkg::ST_OUT;
        end
      end
      tei_pkg::ST_OUT: begin
        if (!ov_q || rsp.ready) begin
          ov_d     = 1'b1;
          o_untr_d = untr_q;
          o_mean_d = untr_q ? 32'd0 : mean_q;
          o_var_d  = untr_q ? 32'd0 : var_q;
          o_exc_d  = untr_q ? 1'b0 : exc_q;
          if (untr_q || root >= 24'(tei_pkg::Q_ONE)) begin
            o_conf_d = '0;
          end else begin
            o_conf_d = tei_pkg::Q_ONE - 17'(root);
          end
          state_d = tei_pkg::ST_IDLE;
        end
      end
      default: state_d = tei_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tei_pkg::ST_IDLE;
      feat_q <= '0;  n_q <= '0;     t_q <= '0;     base_q <= '0;  node_q <= '0;
      steps_q <= '0; lim_q <= '0;   sum_q <= '0;   exc_q <= 1'b0; untr_q <= 1'b0;
      neg_q <= 1'b0; mean_q <= '0;  var_q <= '0;   ss_q <= '0;    a_q <= '0;
      prod_q <= '0;  sv_q <= '0;    sres_q <= '0;  sbit_q <= '0;  scnt_q <= '0;
      ov_q <= 1'b0;  o_mean_q <= '0; o_var_q <= '0; o_conf_q <= '0;
      o_untr_q <= 1'b0; o_exc_q <= 1'b0;
    end else begin
      state_q <= state_d;
      feat_q <= feat_d;  n_q <= n_d;       t_q <= t_d;       base_q <= base_d;
      node_q <= node_d;  steps_q <= steps_d; lim_q <= lim_d; sum_q <= sum_d;
      exc_q <= exc_d;    untr_q <= untr_d; neg_q <= neg_d;   mean_q <= mean_d;
      var_q <= var_d;    ss_q <= ss_d;     a_q <= a_d;       prod_q <= prod_d;
      sv_q <= sv_d;      sres_q <= sres_d; sbit_q <= sbit_d; scnt_q <= scnt_d;
      ov_q <= ov_d;      o_mean_q <= o_mean_d; o_var_q <= o_var_d;
      o_conf_q <= o_conf_d; o_untr_q <= o_untr_d; o_exc_q <= o_exc_d;
    end
  end

  // Table memories, registered reads
  always_ff @(posedge clk_i) begin
    if (split_we) begin
      split_mem[wr_idx] <= {q_item_i.word[63:32], q_item_i.word[4:0]};
    end
    if (link_we) begin
      link_mem[wr_idx] <= q_item_i.word[tei_pkg::LINK_W-1:0];
    end
    split_rd_q <= split_mem[rd_idx];
    link_rd_q  <= link_mem[rd_idx];
  end

  // Per-tree output store
  always_ff @(posedge clk_i) begin
    if (pred_we) begin
      pred_mem[PW'(t_q)] <= pred_wd;
    end
    pred_rd_q <= pred_mem[PW'(t_q)];
  end

  assign rsp.valid           = ov_q;
  assign rsp.predicted_mean  = o_mean_q;
  assign rsp.spread_variance = o_var_q;
  assign rsp.confidence      = o_conf_q;
  assign rsp.untrained       = o_untr_q;
  assign rsp.depth_exceeded  = o_exc_q;

endmodule

>>> src/tree_ensemble_inference_unit.sv
// Top level of the tree ensemble inference unit.
//
// Requests arrive on req_i (valid/ready). A write request (cmd 0) stores one
// split or link word of a node; a predict request (cmd 1) walks trees
// 0..trees_in_use-1 (at most NUM_TREES) and returns one response on rsp_o
// with the mean, the variance, the confidence and the untrained/depth
// flags. Writes give no response. Registers are written through
// cfg_we_i/cfg_idx_i/cfg_data_i. A two-entry queue sits between the request
// side and the walker, so the next request is taken while the current one is
// worked on. A write passes through the queue and lands in the node table
// once the idle sequencer takes it. A predict walks each tree node by node,
// makes a variance pass over the trees, runs two divides and a square root;
// its time is set by the single node-memory read port, the shared serial
// divider and the bit-serial square root.
// The response sits in an output register; while the receiver stalls, the
// walker finishes the next request and then holds until the register frees.
// Reset clears the queue, the sequencer and the registers (trees_in_use 0,
// depth_limit 16); node tables hold no defined content until written.
module tree_ensemble_inference_unit #(
  parameter int unsigned NUM_TREES      = tei_pkg::NUM_TREES_DEF,
  parameter int unsigned NODES_PER_TREE = tei_pkg::NODES_PER_TREE_DEF,
  parameter int unsigned WALK_DEPTH     = tei_pkg::WALK_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tei_in_if.sink                           req_i,
  tei_out_if.source                        rsp_o,
  input  logic                             cfg_we_i,
  input  logic [tei_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tei_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  tei_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;
  logic [3:0]     trees_q;
  logic [4:0]     depth_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trees_q <= tei_pkg::TREES_RESET;
      depth_q <= tei_pkg::DEPTH_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == tei_pkg::CFG_TREES_IN_USE) begin
        trees_q <= cfg_data_i[3:0];
      end else if (cfg_idx_i == tei_pkg::CFG_DEPTH_LIMIT) begin
        depth_q <= cfg_data_i;
      end
    end
  end

  tei_front #(
    .NUM_TREES      (NUM_TREES),
    .NODES_PER_TREE (NODES_PER_TREE)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_i),
    .q_item_o  (q_item),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop)
  );

  tei_back #(
    .NUM_TREES      (NUM_TREES),
    .NODES_PER_TREE (NODES_PER_TREE),
    .WALK_DEPTH     (WALK_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_item_i       (q_item),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .trees_in_use_i (trees_q),
    .depth_limit_i  (depth_q),
    .rsp            (rsp_o)
  );

endmodule

>>> src/tei_checker.sv
// Port-level checks on the response channel of the inference unit.
module tei_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] mean_i,
  input logic [31:0] var_i,
  input logic [16:0] conf_i,
  input logic        untr_i,
  input logic        exc_i
);

  // A stalled response stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // Untrained responses carry zeros
  a_untr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && untr_i |-> mean_i == 32'd0 && var_i == 32'd0 && conf_i == 17'd0 && !exc_i)
    else $error("untrained response with nonzero fields");

  // Confidence never exceeds one
  a_conf_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> conf_i <= 17'h10000)
    else $error("confidence above one");

  // Zero spread gives full confidence
  a_conf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !untr_i && var_i == 32'd0 |-> conf_i == 17'h10000)
    else $error("zero variance without full confidence");

endmodule

bind tree_ensemble_inference_unit tei_checker u_tei_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .mean_i      (rsp_o.predicted_mean),
  .var_i       (rsp_o.spread_variance),
  .conf_i      (rsp_o.confidence),
  .untr_i      (rsp_o.untrained),
  .exc_i       (rsp_o.depth_exceeded)
);

>>> verif/tb_tree_ensemble_inference_unit.sv
// Self-checking testbench for the tree ensemble inference unit.
module tb_tree_ensemble_inference_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH =
    tei_pkg::NUM_TREES_DEF * tei_pkg::NODES_PER_TREE_DEF;
  localparam logic [tei_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 30;

  typedef struct {
    logic                              cmd;
    logic [tei_pkg::ADDR_W-1:0]        addr;
    logic                              wsel;
    logic [tei_pkg::WORD_W-1:0]        word;
    logic signed [tei_pkg::FEAT_W-1:0] feat [tei_pkg::NUM_FEATURES];
  } req_t;

  typedef struct {
    logic signed [31:0]         mean;
    logic [31:0]                variance;
    logic [tei_pkg::CONF_W-1:0] conf;
    logic                       untrained;
    logic                       exceeded;
  } forecast_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [tei_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [tei_pkg::CFG_DATA_W-1:0] cfg_data_i;

  tei_in_if  req_if ();
  tei_out_if rsp_if ();

  tree_ensemble_inference_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the node tables and registers
  logic [63:0] split_mem [TABLE_DEPTH];
  logic [63:0] link_mem  [TABLE_DEPTH];
  logic [3:0]  trees_reg;
  logic [4:0]  depth_reg;

  forecast_t forecasts [$];
  int unsigned errors, n_writes, n_predicts, n_results, n_exceeded, n_saturated;
  int unsigned hold_left, stall_left;
  bit no_gaps;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Integer square root, bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // One tree walk from node 0
  function automatic longint walk_tree(input int t, input req_t rq, input int lim,
                                       inout bit exc);
    int node, steps, code, nxt;
    logic [63:0] s, l;
    longint val, thr;
    node = 0;
    steps = 0;
    forever begin
      s = split_mem[t * tei_pkg::NODES_PER_TREE_DEF + node];
      l = link_mem[t * tei_pkg::NODES_PER_TREE_DEF + node];
      if (s[0]) return longint'($signed(l[49:18]));
      code = s[4:1];
      val = (code < tei_pkg::NUM_FEATURES) ? longint'(rq.feat[code]) : 0;
      thr = longint'($signed(s[63:32]));
      if (val <= thr && l[0]) nxt = l[8:1];
      else if (l[9]) nxt = l[17:10];
      else return 0;
      if (steps >= lim) begin
        exc = 1'b1;
        return 0;
      end
      steps++;
      node = nxt % tei_pkg::NODES_PER_TREE_DEF;
    end
  endfunction

  function automatic forecast_t forest_predict(input req_t rq);
    forecast_t f;
    longint pred [tei_pkg::NUM_TREES_DEF];
    longint sum, mean, d;
    longint unsigned a, sq, hi, lo, var_q, root;
    int n, lim;
    bit exc;
    f = '{default: '0};
    n = (trees_reg > tei_pkg::NUM_TREES_DEF) ? tei_pkg::NUM_TREES_DEF : trees_reg;
    if (n == 0) begin
      f.untrained = 1'b1;
      return f;
    end
    lim = (depth_reg == 0) ? 1 :
          ((depth_reg > tei_pkg::WALK_DEPTH_DEF) ? tei_pkg::WALK_DEPTH_DEF : depth_reg);
    exc = 1'b0;
    sum = 0;
    for (int t = 0; t < n; t++) begin
      pred[t] = walk_tree(t, rq, lim, exc);
      sum += pred[t];
    end
    mean = sum / n;
    hi = 0;
    lo = 0;
    for (int t = 0; t < n; t++) begin
      d = pred[t] - mean;
      a = (d < 0) ? longint'(-d) : longint'(d);
      sq = a * a;
      hi += sq >> 16;
      lo += sq & 64'hFFFF;
    end
    var_q = (hi + (lo >> 16)) / n;
    if (var_q > 64'hFFFF_FFFF) var_q = 64'hFFFF_FFFF;
    root = int_sqrt(var_q << 16);
    f.mean = mean[31:0];
    f.variance = var_q[31:0];
    f.conf = (root < 65536) ? tei_pkg::CONF_W'(65536 - root) : '0;
    f.exceeded = exc;
    return f;
  endfunction

  // Value draws: mostly small, sometimes full range or an extreme
  function automatic logic [31:0] draw_q();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  // Node indices kept written in every tree: 0..15 and 240..255
  function automatic logic [7:0] draw_node();
    int k;
    k = $urandom_range(0, 31);
    return (k < 16) ? 8'(k) : 8'(224 + k);
  endfunction

  function automatic logic [63:0] make_split(input bit allow_leaf);
    logic [63:0] w;
    w = {$urandom, $urandom};
    w[0] = allow_leaf && ($urandom_range(0, 3) == 0);
    w[4:1] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 7));
    w[63:32] = draw_q();
    return w;
  endfunction

  function automatic logic [63:0] make_link();
    logic [63:0] w;
    w = {$urandom, $urandom};
    w[0] = ($urandom_range(0, 5) != 0);
    w[8:1] = draw_node();
    w[9] = ($urandom_range(0, 5) != 0);
    w[17:10] = draw_node();
    w[49:18] = draw_q();
    return w;
  endfunction

  function automatic req_t node_write(input int t, input int node, input bit wsel,
                                      input logic [63:0] w);
    req_t rq;
    rq.cmd = tei_pkg::CMD_WRITE;
    rq.addr = tei_pkg::ADDR_W'(t * tei_pkg::NODES_PER_TREE_DEF + node);
    rq.wsel = wsel;
    rq.word = w;
    foreach (rq.feat[i]) rq.feat[i] = $urandom;
    return rq;
  endfunction

  function automatic req_t predict_req();
    req_t rq;
    rq.cmd = tei_pkg::CMD_PREDICT;
    rq.addr = $urandom;
    rq.wsel = $urandom;
    rq.word = {$urandom, $urandom};
    foreach (rq.feat[i]) rq.feat[i] = draw_q();
    return rq;
  endfunction

  // Sends one request and updates the shadow state when it is taken
  task automatic send_req(input req_t rq);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.cmd                <= rq.cmd;
    req_if.node_address       <= rq.addr;
    req_if.word_select        <= rq.wsel;
    req_if.node_word          <= rq.word;
    req_if.sma_short_ratio    <= rq.feat[0];
    req_if.sma_long_ratio     <= rq.feat[1];
    req_if.rsi_value          <= rq.feat[2];
    req_if.volatility_value   <= rq.feat[3];
    req_if.volume_ratio_value <= rq.feat[4];
    req_if.momentum_short     <= rq.feat[5];
    req_if.momentum_long      <= rq.feat[6];
    req_if.sentiment_value    <= rq.feat[7];
    req_if.valid              <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (rq.cmd == tei_pkg::CMD_WRITE) begin
      n_writes++;
      if (rq.addr < TABLE_DEPTH) begin
        if (rq.wsel == tei_pkg::WSEL_LINK) begin
          link_mem[rq.addr] = rq.word & 64'h0003_FFFF_FFFF_FFFF;
        end else begin
          split_mem[rq.addr] = rq.word & 64'hFFFF_FFFF_0000_001F;
        end
      end
    end else begin
      n_predicts++;
      forecasts.insert(forecasts.size(), forest_predict(rq));
    end
  endtask

  // Lets everything in flight drain before touching registers
  task automatic wait_quiet();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (forecasts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tei_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tei_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tei_pkg::CFG_TREES_IN_USE) trees_reg = d[3:0];
    else if (idx == tei_pkg::CFG_DEPTH_LIMIT) depth_reg = d;
  endtask

  task automatic set_regs(input logic [4:0] trees, input logic [4:0] depth);
    wait_quiet();
    write_reg(tei_pkg::CFG_TREES_IN_USE, trees);
    write_reg(tei_pkg::CFG_DEPTH_LIMIT, depth);
  endtask

  // Fill the node range used by the walks in every tree
  task automatic test_load_forest();
    for (int t = 0; t < tei_pkg::NUM_TREES_DEF; t++) begin
      for (int k = 0; k < 32; k++) begin
        send_req(node_write(t, (k < 16) ? k : 224 + k, tei_pkg::WSEL_SPLIT,
                            make_split(1'b1)));
        send_req(node_write(t, (k < 16) ? k : 224 + k, tei_pkg::WSEL_LINK, make_link()));
      end
    end
  endtask

  // Untrained model, leaf extremes, depth limit, missing child, unknown feature
  task automatic test_directed();
    logic [63:0] w;
    set_regs(5'd0, 5'd16);
    send_req(predict_req());
    w = '0;
    w[0] = 1'b1;
    send_req(node_write(0, 0, tei_pkg::WSEL_SPLIT, w));
    send_req(node_write(1, 0, tei_pkg::WSEL_SPLIT, w));
    w = '0;
    w[49:18] = 32'h7FFF_FFFF;
    send_req(node_write(0, 0, tei_pkg::WSEL_LINK, w));
    w[49:18] = 32'h8000_0000;
    send_req(node_write(1, 0, tei_pkg::WSEL_LINK, w));
    set_regs(5'd2, 5'd16);
    send_req(predict_req());
    set_regs(5'd1, 5'd16);
    send_req(predict_req());
    // tree 0: node 0 always goes left to node 1; node 1 tests an unknown
    // feature (reads 0) against -1 and loops back right to node 0
    w = '0;
    w[63:32] = 32'h7FFF_FFFF;
    send_req(node_write(0, 0, tei_pkg::WSEL_SPLIT, w));
    w = '0;
    w[0] = 1'b1;
    w[8:1] = 8'd1;
    send_req(node_write(0, 0, tei_pkg::WSEL_LINK, w));
    w = '0;
    w[4:1] = 4'd12;
    w[63:32] = 32'hFFFF_FFFF;
    send_req(node_write(0, 1, tei_pkg::WSEL_SPLIT, w));
    w = '0;
    w[9] = 1'b1;
    send_req(node_write(0, 1, tei_pkg::WSEL_LINK, w));
    set_regs(5'd1, 5'd0);
    send_req(predict_req());
    set_regs(5'd15, 5'd31);
    send_req(predict_req());
    // missing child: node 1 without a right link yields 0
    w = '0;
    send_req(node_write(0, 1, tei_pkg::WSEL_LINK, w));
    wait_quiet();
    write_reg(CFG_SPARE, 5'b11111);
    send_req(predict_req());
  endtask

  // Receiver stalls for a long stretch while requests keep coming
  task automatic test_backpressure();
    set_regs(5'd8, 5'd16);
    no_gaps = 1'b1;
    hold_left = 2000;
    repeat (12) send_req(predict_req());
    no_gaps = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [4:0] trees, depth;
    for (int ph = 0; ph < 8; ph++) begin
      trees = (ph == 0) ? 5'd8 : 5'($urandom_range(0, 15));
      depth = (ph == 1) ? 5'd1 : (ph == 2) ? 5'd31 : 5'($urandom_range(0, 31));
      set_regs(trees, depth);
      no_gaps = (ph % 3 == 2);
      repeat (45) begin
        if ($urandom_range(0, 9) < 4)
          send_req(node_write($urandom_range(0, 7), draw_node(), $urandom,
                              ($urandom_range(0, 1) == 0) ? make_split(1'b1) : make_link()));
        else
          send_req(predict_req());
      end
    end
    no_gaps = 1'b0;
  endtask

  // Response side: long hold first, then a drawn stall per response
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Compare each response with the oldest forecast
  always @(posedge clk_i) begin
    forecast_t e;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      n_results++;
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (forecasts.size() == 0) begin
        $display("%0t: response with nothing outstanding", $realtime);
        errors++;
      end else begin
        e = forecasts.pop_front();
        if (e.exceeded) n_exceeded++;
        if (e.variance == 32'hFFFF_FFFF) n_saturated++;
        if (rsp_if.predicted_mean !== e.mean) begin
          $display("%0t: predicted_mean exp %h got %h", $realtime, e.mean,
                   rsp_if.predicted_mean);
          errors++;
        end
        if (rsp_if.spread_variance !== e.variance) begin
          $display("%0t: spread_variance exp %h got %h", $realtime, e.variance,
                   rsp_if.spread_variance);
          errors++;
        end
        if (rsp_if.confidence !== e.conf) begin
          $display("%0t: confidence exp %h got %h", $realtime, e.conf, rsp_if.confidence);
          errors++;
        end
        if (rsp_if.untrained !== e.untrained) begin
          $display("%0t: untrained exp %b got %b", $realtime, e.untrained,
                   rsp_if.untrained);
          errors++;
        end
        if (rsp_if.depth_exceeded !== e.exceeded) begin
          $display("%0t: depth_exceeded exp %b got %b", $realtime, e.exceeded,
                   rsp_if.depth_exceeded);
          errors++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("tree_ensemble_inference_unit regression: fail");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.cmd = tei_pkg::CMD_WRITE;
    req_if.node_address = '0;
    req_if.word_select = tei_pkg::WSEL_SPLIT;
    req_if.node_word = '0;
    req_if.sma_short_ratio = '0;
    req_if.sma_long_ratio = '0;
    req_if.rsi_value = '0;
    req_if.volatility_value = '0;
    req_if.volume_ratio_value = '0;
    req_if.momentum_short = '0;
    req_if.momentum_long = '0;
    req_if.sentiment_value = '0;
    trees_reg = tei_pkg::TREES_RESET;
    depth_reg = tei_pkg::DEPTH_RESET;
    foreach (split_mem[i]) begin
      split_mem[i] = '0;
      link_mem[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_load_forest();
    test_directed();
    test_backpressure();
    test_random_phases();
    wait_quiet();

    $display("Covered %0d node writes and %0d predicts, %0d responses checked;",
             n_writes, n_predicts, n_results);
    $display("%0d walks over the depth limit, %0d saturated variances, %0d mismatches.",
             n_exceeded, n_saturated, errors);
    if (errors == 0 && forecasts.size() == 0) begin
      $display("tree_ensemble_inference_unit regression: pass");
    end else begin
      $display("tree_ensemble_inference_unit regression: fail");
    end
    $finish;
  end

endmodule
